// File: sv/switch_debounce_hold_events_top_defines.svh
// Assertion macros shared by the block's checking code.
`ifndef SWITCH_DEBOUNCE_HOLD_EVENTS_TOP_DEFINES_SVH
`define SWITCH_DEBOUNCE_HOLD_EVENTS_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SDHE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SDHE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/sdhe_pkg.sv
`default_nettype none
package sdhe_pkg;

   localparam int NUM_SWITCHES_DEF = 8;
   localparam int PIN_W            = 8;
   localparam int EV_W             = 3;
   localparam int EVENTS_W         = EV_W * PIN_W;
   localparam int CNT_W            = 8;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 32;

   localparam logic [CNT_W-1:0] DEBOUNCE_COUNT_RST = 8'd8;
   localparam logic [CNT_W-1:0] HOLD_COUNT_RST     = 8'd50;
   localparam logic [CNT_W-1:0] REPEAT_COUNT_RST   = 8'd100;
   localparam logic             PRESSED_LEVEL_RST  = 1'b0;

   typedef enum logic [EV_W-1:0] {
      EV_NONE          = 3'd0,
      EV_PRESS         = 3'd1,
      EV_SHORT_RELEASE = 3'd2,
      EV_HOLD_RELEASE  = 3'd3,
      EV_HOLD          = 3'd4
   } ev_type;

   typedef enum logic [1:0] {
      REG_DEBOUNCE_COUNT = 2'd0,
      REG_HOLD_COUNT     = 2'd1,
      REG_REPEAT_COUNT   = 2'd2,
      REG_PRESSED_LEVEL  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_count;
      logic [CNT_W-1:0] hold_count;
      logic [CNT_W-1:0] repeat_count;
      logic             pressed_level;
   } cfg_type;

   typedef struct packed {
      ev_type ev;
      logic   pressed;
   } lane_out_type;

endpackage
`default_nettype wire

// File: sv/sdhe_channels.sv
`default_nettype none
interface sdhe_req_if import sdhe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface

interface sdhe_rsp_if import sdhe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [EVENTS_W-1:0] events;
   logic [PIN_W-1:0]    pressed_flags;
   logic                any_event;

   modport source (output valid, output events, output pressed_flags, output any_event,
                   input ready);
   modport sink   (input valid, input events, input pressed_flags, input any_event,
                   output ready);
endinterface
`default_nettype wire

// File: sv/sdhe_lane.sv
`default_nettype none
module sdhe_lane import sdhe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         level,
   input  cfg_type      cfg,
   output lane_out_type result
);

   logic             pressed_ff, pressed_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [CNT_W-1:0] hcnt_ff, hcnt_in;
   logic             raw_pressed;
   logic [CNT_W-1:0] dcnt_inc;
   logic [CNT_W-1:0] hcnt_inc;
   ev_type           ev;

   always_comb begin
      raw_pressed = (level == cfg.pressed_level);
      dcnt_inc    = dcnt_ff + 8'd1;
      hcnt_inc    = hcnt_ff + 8'd1;
      pressed_in  = pressed_ff;
      dcnt_in     = '0;
      hcnt_in     = hcnt_ff;
      ev          = EV_NONE;

      if (raw_pressed != pressed_ff) begin
         if (dcnt_inc == cfg.debounce_count) begin
            pressed_in = raw_pressed;
         end else begin
            dcnt_in = dcnt_inc;
         end
      end

      if (pressed_in && !pressed_ff) begin
         hcnt_in = '0;
         ev      = EV_PRESS;
      end else if (!pressed_in && pressed_ff) begin
         ev = (hcnt_ff < cfg.hold_count) ? EV_SHORT_RELEASE : EV_HOLD_RELEASE;
      end else if (pressed_in && (hcnt_ff < cfg.repeat_count)) begin
         hcnt_in = hcnt_inc;
         if (hcnt_inc == cfg.hold_count) begin
            ev = EV_HOLD;
         end
         // repeat point: fire again and rewind to the first-hold mark
         if (hcnt_inc == cfg.repeat_count) begin
            ev      = EV_HOLD;
            hcnt_in = cfg.hold_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         dcnt_ff    <= '0;
         hcnt_ff    <= '0;
      end else if (accept) begin
         pressed_ff <= pressed_in;
         dcnt_ff    <= dcnt_in;
         hcnt_ff    <= hcnt_in;
      end
   end

   assign result.ev      = ev;
   assign result.pressed = pressed_in;

endmodule
`default_nettype wire

// File: sv/sdhe_merge.sv
`default_nettype none
module sdhe_merge import sdhe_pkg::*; #(
   parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lane_out_type        lanes [NUM_SWITCHES],
   input  logic                out_ready,
   output logic                out_valid,
   output logic [EVENTS_W-1:0] events,
   output logic [PIN_W-1:0]    pressed_flags,
   output logic                any_event
);

   logic                valid_ff, valid_in;
   logic [EVENTS_W-1:0] events_ff, events_in;
   logic [PIN_W-1:0]    flags_ff, flags_in;
   logic                any_ff, any_in;

   for (genvar i = 0; i < PIN_W; i++) begin : g_pack
      if (i < NUM_SWITCHES) begin : g_used
         assign events_in[EV_W*i +: EV_W] = lanes[i].ev;
         assign flags_in[i]               = lanes[i].pressed;
      end else begin : g_unused
         assign events_in[EV_W*i +: EV_W] = EV_NONE;
         assign flags_in[i]               = 1'b0;
      end
   end

   assign any_in   = |events_in;
   assign valid_in = accept | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         events_ff <= events_in;
         flags_ff  <= flags_in;
         any_ff    <= any_in;
      end
   end

   assign out_valid     = valid_ff;
   assign events        = events_ff;
   assign pressed_flags = flags_ff;
   assign any_event     = any_ff;

endmodule
`default_nettype wire

// File: sv/sdhe_csr.sv
`default_nettype none
module sdhe_csr import sdhe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_DEBOUNCE_COUNT: cfg_in.debounce_count = pwdata[CNT_W-1:0];
            REG_HOLD_COUNT:     cfg_in.hold_count     = pwdata[CNT_W-1:0];
            REG_REPEAT_COUNT:   cfg_in.repeat_count   = pwdata[CNT_W-1:0];
            REG_PRESSED_LEVEL:  cfg_in.pressed_level  = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DEBOUNCE_COUNT: prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.debounce_count};
         REG_HOLD_COUNT:     prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.hold_count};
         REG_REPEAT_COUNT:   prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.repeat_count};
         REG_PRESSED_LEVEL:  prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.pressed_level};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count <= DEBOUNCE_COUNT_RST;
         cfg_ff.hold_count     <= HOLD_COUNT_RST;
         cfg_ff.repeat_count   <= REPEAT_COUNT_RST;
         cfg_ff.pressed_level  <= PRESSED_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: sv/switch_debounce_hold_events_top.sv
`default_nettype none
// Switch debouncer with press, short release, hold release and auto-repeat hold events.
// Each req_ transaction is one tick's pin sample; every switch has its own lane holding a
// debounced level, a debounce counter and a hold counter, and the lanes are packed into one
// rsp_ transaction per tick (three event bits per switch, debounced pressed flags and an
// any-event bit). Throughput is one sample per clock unless stalled: the only work is a
// compare and an 8-bit increment inside each lane, and the result leaves through a single
// output register in the cycle after the sample is taken. A new sample is accepted whenever
// that register is empty or being drained in the same cycle. Registers sit at byte offsets
// 0 (debounce count), 4 (hold count), 8 (repeat count) and 12 (pressed level); change them
// only while no transaction is in flight. Repeat count should exceed hold count.
`include "switch_debounce_hold_events_top_defines.svh"
module switch_debounce_hold_events_top import sdhe_pkg::*; #(
   parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sdhe_req_if.sink              req_chan,
   sdhe_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   logic         accept;
   logic         lane_level [NUM_SWITCHES];
   lane_out_type lane_res   [NUM_SWITCHES];

   assign req_chan.ready = ~rsp_chan.valid | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   sdhe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_lane
      if (i < PIN_W) begin : g_pin
         assign lane_level[i] = req_chan.pin_levels[i];
      end else begin : g_nopin
         assign lane_level[i] = 1'b0;
      end

      sdhe_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (accept),
         .level  (lane_level[i]),
         .cfg    (cfg),
         .result (lane_res[i])
      );
   end

   sdhe_merge #(
      .NUM_SWITCHES (NUM_SWITCHES)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .lanes         (lane_res),
      .out_ready     (rsp_chan.ready),
      .out_valid     (rsp_chan.valid),
      .events        (rsp_chan.events),
      .pressed_flags (rsp_chan.pressed_flags),
      .any_event     (rsp_chan.any_event)
   );

   `SDHE_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_chan.valid, "accepted sample gave no result")
   `SDHE_ASSERT_IMP(a_idle_takes_req, !rsp_chan.valid, req_chan.ready, "empty output but not ready")
   `SDHE_ASSERT_IMP(a_any_event_matches, rsp_chan.valid,
      rsp_chan.any_event == (rsp_chan.events != '0), "any_event disagrees with events")
   `SDHE_ASSERT_IMP(a_press_sets_flag, rsp_chan.valid && (rsp_chan.events[EV_W-1:0] == EV_PRESS),
      rsp_chan.pressed_flags[0], "press event without pressed flag")

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
   import sdhe_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int BLOCK_ITEMS    = 18;
   localparam int BLOCKS_PER_RUN = 6;

   localparam logic [PIN_W-1:0] DIRECTED_PINS [20] = '{
      8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
      8'h0F, 8'hF0, 8'hF0, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'hF0, 8'hF0, 8'hF0
   };

   typedef struct packed {
      logic [EVENTS_W-1:0] events;
      logic [PIN_W-1:0]    pressed_flags;
      logic                any_event;
   } tick_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sdhe_req_if req_bus ();
   sdhe_rsp_if rsp_bus ();

   switch_debounce_hold_events_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // switch model state, pressed polarity (1 = pressed)
   cfg_type          cfg;
   logic [PIN_W-1:0] lane_pressed;
   logic [CNT_W-1:0] bounce_cnt [PIN_W];
   logic [CNT_W-1:0] held_cnt [PIN_W];

   tick_result_type  pending_results [$];
   int unsigned      event_tally [8];
   int unsigned      error_count;
   int unsigned      samples_sent;
   int unsigned      results_checked;
   int unsigned      settings_written;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;

   // raw pin level per lane for the random episodes, and ticks left in each
   logic [PIN_W-1:0] lane_pins;
   int unsigned      lane_left [PIN_W];

   initial begin
      clock = 1'b0;
   end

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("simulation failed");
      $finish;
   end

   function automatic void reset_model();
      cfg.debounce_count = DEBOUNCE_COUNT_RST;
      cfg.hold_count     = HOLD_COUNT_RST;
      cfg.repeat_count   = REPEAT_COUNT_RST;
      cfg.pressed_level  = PRESSED_LEVEL_RST;
      lane_pressed       = '0;
      for (int i = 0; i < PIN_W; i++) begin
         bounce_cnt[i] = '0;
         held_cnt[i]   = '0;
      end
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(reg_idx_type idx);
      case (idx)
         REG_DEBOUNCE_COUNT: return CSR_DATA_W'(cfg.debounce_count);
         REG_HOLD_COUNT:     return CSR_DATA_W'(cfg.hold_count);
         REG_REPEAT_COUNT:   return CSR_DATA_W'(cfg.repeat_count);
         default:            return CSR_DATA_W'(cfg.pressed_level);
      endcase
   endfunction

   function automatic tick_result_type predict_tick(logic [PIN_W-1:0] pins);
      tick_result_type res;
      logic            raw;
      logic            was;
      logic            now;
      ev_type          ev;
      res = '0;
      for (int i = 0; i < PIN_W; i++) begin
         raw = (pins[i] == cfg.pressed_level);
         was = lane_pressed[i];
         now = was;
         ev  = EV_NONE;
         if (raw != was) begin
            bounce_cnt[i] = bounce_cnt[i] + 1'b1;
            if (bounce_cnt[i] == cfg.debounce_count) begin
               now           = raw;
               bounce_cnt[i] = '0;
            end
         end else begin
            bounce_cnt[i] = '0;
         end
         if (now && !was) begin
            held_cnt[i] = '0;
            ev          = EV_PRESS;
         end else if (!now && was) begin
            if (held_cnt[i] < cfg.hold_count) begin
               ev = EV_SHORT_RELEASE;
            end else begin
               ev = EV_HOLD_RELEASE;
            end
         end else if (now && held_cnt[i] < cfg.repeat_count) begin
            held_cnt[i] = held_cnt[i] + 1'b1;
            if (held_cnt[i] == cfg.hold_count) begin
               ev = EV_HOLD;
            end
            if (held_cnt[i] == cfg.repeat_count) begin
               ev          = EV_HOLD;
               held_cnt[i] = cfg.hold_count;
            end
         end
         lane_pressed[i]              = now;
         res.events[EV_W*i +: EV_W]   = ev;
         event_tally[ev]++;
      end
      res.pressed_flags = lane_pressed;
      res.any_event     = |res.events;
      return res;
   endfunction

   // result side: random back-pressure, compare on every accepted transaction
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with no sample outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_bus.events !== want.events) begin
               $error("events: expected %06h, got %06h", want.events, rsp_bus.events);
               error_count++;
            end
            if (rsp_bus.pressed_flags !== want.pressed_flags) begin
               $error("pressed_flags: expected %02h, got %02h",
                      want.pressed_flags, rsp_bus.pressed_flags);
               error_count++;
            end
            if (rsp_bus.any_event !== want.any_event) begin
               $error("any_event: expected %0b, got %0b", want.any_event, rsp_bus.any_event);
               error_count++;
            end
         end
      end
   end

   task automatic send_sample(logic [PIN_W-1:0] pins);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.pin_levels <= PIN_W'($urandom);
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.pin_levels <= pins;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      pending_results.push_back(predict_tick(pins));
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic read_reg(reg_idx_type idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== reg_value(idx)) begin
         $error("%s readback: expected %0h, got %0h", idx.name(), reg_value(idx), csr_prdata);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // upper data bits are junk on purpose; only the register's width is kept
   task automatic write_reg(reg_idx_type idx, logic [CNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = {$urandom} & ~CSR_DATA_W'(8'hFF) | CSR_DATA_W'(value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      case (idx)
         REG_DEBOUNCE_COUNT: cfg.debounce_count = data[CNT_W-1:0];
         REG_HOLD_COUNT:     cfg.hold_count     = data[CNT_W-1:0];
         REG_REPEAT_COUNT:   cfg.repeat_count   = data[CNT_W-1:0];
         default:            cfg.pressed_level  = data[0];
      endcase
      settings_written++;
      read_reg(idx);
   endtask

   task automatic set_timing(logic [CNT_W-1:0] debounce, logic [CNT_W-1:0] hold,
                             logic [CNT_W-1:0] rpt, logic level);
      wait_idle();
      write_reg(REG_DEBOUNCE_COUNT, debounce);
      write_reg(REG_HOLD_COUNT, hold);
      write_reg(REG_REPEAT_COUNT, rpt);
      write_reg(REG_PRESSED_LEVEL, CNT_W'(level));
   endtask

   task automatic test_reset_defaults();
      read_reg(REG_DEBOUNCE_COUNT);
      read_reg(REG_HOLD_COUNT);
      read_reg(REG_REPEAT_COUNT);
      read_reg(REG_PRESSED_LEVEL);
      // pull-up default: low pins are pressed, too short to be accepted
      repeat (4) send_sample(8'h00);
      repeat (2) send_sample(8'hFF);
   endtask

   // press, bounce, hold, auto-repeat, hold release, short release, chatter
   task automatic test_directed_events();
      set_timing(8'd2, 8'd2, 8'd4, 1'b1);
      foreach (DIRECTED_PINS[k]) begin
         send_sample(DIRECTED_PINS[k]);
      end
   endtask

   // polarity flipped while the upper switches are held down
   task automatic test_polarity_change();
      wait_idle();
      write_reg(REG_PRESSED_LEVEL, CNT_W'(1'b0));
      repeat (3) send_sample(8'hF0);
      repeat (3) send_sample(8'h0F);
   endtask

   task automatic test_count_extremes();
      // debounce of zero wraps to 256 samples; repeat not above hold stops holds
      set_timing(8'd0, 8'd0, 8'd0, 1'b1);
      for (int k = 0; k < 260; k++) begin
         send_sample((k == 100) ? 8'hFE : 8'hFF);
      end
      for (int k = 0; k < 260; k++) begin
         send_sample(8'h0F);
      end
      // longest hold counts: late first hold, then a repeat on every tick
      set_timing(8'd1, 8'd254, 8'd255, 1'b0);
      repeat (260) send_sample(8'h00);
      repeat (2) send_sample(8'hFF);
      set_timing(8'd1, 8'd255, 8'd255, 1'b1);
      repeat (260) send_sample(8'hFF);
      repeat (2) send_sample(8'h00);
   endtask

   task automatic run_random_block();
      int unsigned      span;
      logic [PIN_W-1:0] pins;
      span = ((cfg.debounce_count == 0) ? 256 : cfg.debounce_count) + cfg.repeat_count + 4;
      for (int i = 0; i < PIN_W; i++) begin
         lane_left[i] = $urandom_range(span, 1);
      end
      repeat (BLOCK_ITEMS) begin
         for (int i = 0; i < PIN_W; i++) begin
            if (lane_left[i] == 0) begin
               lane_pins[i] = ~lane_pins[i];
               lane_left[i] = $urandom_range(span, 1);
            end
            lane_left[i]--;
         end
         pins = lane_pins;
         if ($urandom_range(9) == 0) begin
            pins ^= PIN_W'(1) << $urandom_range(PIN_W - 1);
         end else if ($urandom_range(39) == 0) begin
            pins = PIN_W'($urandom);
         end
         send_sample(pins);
      end
   endtask

   task automatic test_random(int unsigned send_pct, int unsigned recv_pct);
      logic [CNT_W-1:0] debounce;
      logic [CNT_W-1:0] hold;
      logic [CNT_W-1:0] rpt;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (BLOCKS_PER_RUN) begin
         case ($urandom_range(9))
            0: begin
               debounce = CNT_W'($urandom);
               hold     = CNT_W'($urandom);
               rpt      = CNT_W'($urandom);
            end
            1, 2: begin
               debounce = CNT_W'($urandom_range(4, 1));
               hold     = CNT_W'($urandom_range(10));
               rpt      = CNT_W'($urandom_range(hold));
            end
            default: begin
               debounce = CNT_W'($urandom_range(4, 1));
               hold     = CNT_W'($urandom_range(8, 1));
               rpt      = hold + CNT_W'($urandom_range(6, 1));
            end
         endcase
         set_timing(debounce, hold, rpt, 1'($urandom));
         run_random_block();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.pin_levels = '0;
      rsp_bus.ready      = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      error_count        = 0;
      samples_sent       = 0;
      results_checked    = 0;
      settings_written   = 0;
      send_idle_pct      = 22;
      recv_idle_pct      = 67;
      lane_pins          = '1;
      foreach (event_tally[k]) begin
         event_tally[k] = 0;
      end
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_directed_events();
      test_polarity_change();
      test_count_extremes();
      test_random(22, 67);
      test_random(67, 22);
      test_random(0, 0);

      wait_idle();
      repeat (5) @(negedge clock);
      $display("%0d pin samples sent, %0d results checked, %0d register writes",
               samples_sent, results_checked, settings_written);
      $display("events seen: %0d press, %0d short release, %0d hold release, %0d hold",
               event_tally[EV_PRESS], event_tally[EV_SHORT_RELEASE],
               event_tally[EV_HOLD_RELEASE], event_tally[EV_HOLD]);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
